// ===== sv/rpfc_pkg.sv =====
// shared types and constants of the rf period/frequency classifier
package rpfc_pkg;

    localparam int STAMP_BITS   = 16;
    localparam int IN_TDATA_W   = ((STAMP_BITS + 7) / 8) * 8;
    localparam int PERIOD_W     = 8;
    localparam int CNT_W        = 6;
    localparam int MHZ_W        = 11;
    localparam int HUN_W        = 7;
    localparam int CLS_W        = 2;
    localparam int OUT_FIELDS_W = MHZ_W + HUN_W + CLS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // request kinds
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_EDGE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    // modulation classes
    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [CLS_W-1:0] CLS_FSK     = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ASK     = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_MIN_PERIOD = 2'd0;
    localparam logic [1:0] CFG_MAX_PERIOD = 2'd1;
    localparam logic [1:0] CFG_SCAN_LIMIT = 2'd2;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 8'd13;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 8'd46;
    localparam logic [CNT_W-1:0]    SCAN_LIMIT_RST = 6'd32;
    localparam logic [CNT_W-1:0]    CNT_MAX        = 6'd63;

    // divider: dividend and divisor widths
    localparam int DIV_N     = 28;
    localparam int DIV_D     = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_N + 1);

    // 108e6 / base, then *128 / 1e6 = 2q / 15625, remainder*64/1000 = r*8/125
    localparam int MQ_W   = 14;
    localparam int KILO_W = 10;
    localparam logic [DIV_N-1:0]  REF_HZ    = 28'd108000000;
    localparam logic [MQ_W-1:0]   MHZ_DIV   = 14'd15625;
    localparam logic [KILO_W-1:0] HUN_BIAS  = 10'd5;
    localparam logic [MQ_W-1:0]   MHZ_LIMIT = 14'd2047;

    // floor division by a constant: multiply by the rounded-up reciprocal, shift
    localparam int RECIP_MHZ_W  = 29;
    localparam int RECIP_MHZ_SH = 42;
    localparam int PROD1_W      = DIV_N + RECIP_MHZ_W;
    localparam logic [RECIP_MHZ_W-1:0] RECIP_MHZ = 29'd281474977;

    // 8r / 125 folded into one shift: r * ceil(2^24 / 125) >> 21
    localparam int RECIP_KILO_W  = 18;
    localparam int RECIP_KILO_SH = 21;
    localparam int PROD2_W       = MQ_W + RECIP_KILO_W;
    localparam logic [RECIP_KILO_W-1:0] RECIP_KILO = 18'd134218;

    localparam int RECIP_HUN_W  = 8;
    localparam int RECIP_HUN_SH = 11;
    localparam int PROD3_W      = KILO_W + RECIP_HUN_W;
    localparam logic [RECIP_HUN_W-1:0] RECIP_HUN = 8'd205;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one finished run handed to the back end
    typedef struct packed {
        logic                ok;
        logic [PERIOD_W-1:0] base;
        logic [CLS_W-1:0]    cls;
    } job_t;

endpackage

// ===== sv/rpfc_front.sv =====
// request decoder: run state, interval checks and classification
module rpfc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [rpfc_pkg::PERIOD_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_req,
    input  logic [rpfc_pkg::STAMP_BITS-1:0] in_stamp,
    input  logic                           q_full,
    output logic                           push,
    output rpfc_pkg::job_t                 job
);
    import rpfc_pkg::*;

    localparam int W2 = STAMP_BITS + 2;

    logic [PERIOD_W-1:0]   min_period_reg;
    logic [PERIOD_W-1:0]   max_period_reg;
    logic [CNT_W-1:0]      scan_limit_reg;

    logic [STAMP_BITS-1:0] prev_stamp_reg, prev_stamp_next;
    logic [CNT_W-1:0]      edge_count_reg, edge_count_next;
    logic [STAMP_BITS-1:0] base_reg, base_next;
    logic [CLS_W-1:0]      class_held_reg, class_held_next;
    logic                  active_reg, active_next;

    logic                  accept;
    logic [STAMP_BITS-1:0] iv;
    logic [CNT_W-1:0]      cnt_inc;
    logic [STAMP_BITS-1:0] base_edge;
    logic [W2-1:0]         iv_w, c2, c3;
    logic                  near2, near3;
    logic                  fin;
    logic [CLS_W-1:0]      fin_cls;
    logic [STAMP_BITS-1:0] fin_base;

    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign iv        = in_stamp - prev_stamp_reg;
    assign cnt_inc   = (edge_count_reg == CNT_MAX) ? edge_count_reg : edge_count_reg + 1'b1;
    assign base_edge = (cnt_inc == CNT_W'(2)) ? iv : base_reg;

    // "about n times": n*base - 1 <= iv <= n*base + 1, no wrap
    assign iv_w  = W2'(iv);
    assign c2    = W2'(base_reg) << 1;
    assign c3    = (W2'(base_edge) << 1) + W2'(base_edge);
    assign near2 = (iv_w + W2'(1) >= c2) && (iv_w <= c2 + W2'(1));
    assign near3 = (iv_w + W2'(1) >= c3) && (iv_w <= c3 + W2'(1));

    always_comb
    begin
        prev_stamp_next = prev_stamp_reg;
        edge_count_next = edge_count_reg;
        base_next       = base_reg;
        class_held_next = class_held_reg;
        active_next     = active_reg;
        fin             = 1'b0;
        fin_cls         = class_held_reg;
        fin_base        = base_reg;
        if (accept)
        begin
            case (in_req)
                REQ_START:
                begin
                    active_next     = 1'b1;
                    edge_count_next = '0;
                    base_next       = '0;
                end
                REQ_TIMEOUT:
                begin
                    fin = active_reg;
                end
                REQ_EDGE:
                begin
                    if (active_reg)
                    begin
                        prev_stamp_next = in_stamp;
                        edge_count_next = cnt_inc;
                        fin_base        = base_edge;
                        if (cnt_inc == CNT_W'(1))
                        begin
                            edge_count_next = cnt_inc;
                        end
                        else if (cnt_inc == CNT_W'(2) &&
                                 base_edge > STAMP_BITS'(max_period_reg))
                        begin
                            edge_count_next = '0;
                            base_next       = base_edge;
                        end
                        else if (cnt_inc == CNT_W'(3))
                        begin
                            if (near2)
                                edge_count_next = '0;
                        end
                        else if (near3)
                        begin
                            fin     = 1'b1;
                            fin_cls = CLS_ASK;
                        end
                        else if (cnt_inc >= scan_limit_reg)
                        begin
                            fin     = 1'b1;
                            fin_cls = CLS_FSK;
                        end
                        else
                        begin
                            base_next = base_edge;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (fin)
            begin
                class_held_next = fin_cls;
                active_next     = 1'b0;
                edge_count_next = '0;
                base_next       = '0;
            end
        end
    end

    assign push     = fin;
    assign job.ok   = (fin_base != '0) &&
                      (fin_base >= STAMP_BITS'(min_period_reg)) &&
                      (fin_base <= STAMP_BITS'(max_period_reg));
    assign job.base = fin_base[PERIOD_W-1:0];
    assign job.cls  = fin_cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
            scan_limit_reg <= SCAN_LIMIT_RST;
            prev_stamp_reg <= '0;
            edge_count_reg <= '0;
            base_reg       <= '0;
            class_held_reg <= CLS_UNKNOWN;
            active_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_PERIOD: min_period_reg <= cfg_data;
                    CFG_MAX_PERIOD: max_period_reg <= cfg_data;
                    CFG_SCAN_LIMIT: scan_limit_reg <= cfg_data[CNT_W-1:0];
                    default:        ;
                endcase
            end
            prev_stamp_reg <= prev_stamp_next;
            edge_count_reg <= edge_count_next;
            base_reg       <= base_next;
            class_held_reg <= class_held_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ===== sv/rpfc_queue.sv =====
// two-entry queue of finished runs between front and back end
module rpfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rpfc_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output rpfc_pkg::job_t rdata
);
    import rpfc_pkg::*;

    job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/rpfc_div.sv =====
// restoring divider, one quotient bit per cycle
module rpfc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rpfc_pkg::DIV_N-1:0]  dividend,
    input  logic [rpfc_pkg::DIV_D-1:0]  divisor,
    output logic                        done,
    output logic [rpfc_pkg::DIV_N-1:0]  quot
);
    import rpfc_pkg::*;

    logic [DIV_N-1:0]     dvd_reg;
    logic [DIV_D-1:0]     dsr_reg;
    logic [DIV_D-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DIV_D:0]       trial;
    logic                 ge;
    logic [DIV_D:0]       diff;

    assign trial = {rem_reg, dvd_reg[DIV_N-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    assign done = done_reg;
    assign quot = dvd_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DIV_N-2:0], ge};
            rem_reg <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == DIV_CNT_W'(1));
            if (start)
                cnt_reg <= DIV_CNT_W'(DIV_N);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== sv/rpfc_back.sv =====
// frequency sequencer: one divider pass and reciprocal multiplies for a valid base, output register
module rpfc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  rpfc_pkg::job_t                q_job,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_ok,
    output logic [rpfc_pkg::MHZ_W-1:0]    out_mhz,
    output logic [rpfc_pkg::HUN_W-1:0]    out_hun,
    output logic [rpfc_pkg::CLS_W-1:0]    out_cls
);
    import rpfc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_QUOT = 7'b0000010,
        ST_MHZ  = 7'b0000100,
        ST_REM  = 7'b0001000,
        ST_KILO = 7'b0010000,
        ST_HUN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic               ok_reg, ok_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [MHZ_W-1:0]   mhz_reg, mhz_next;
    logic [HUN_W-1:0]   hun_reg, hun_next;
    logic               div_start_reg, div_start_next;
    logic [DIV_D-1:0]   div_dsr_reg, div_dsr_next;
    logic [DIV_N-1:0]   twoq_reg, twoq_next;
    logic [MQ_W-1:0]    mq_reg, mq_next;
    logic [MQ_W-1:0]    frac_reg, frac_next;
    logic [KILO_W-1:0]  kilo_reg, kilo_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg;
    logic [MHZ_W-1:0]   out_mhz_reg;
    logic [HUN_W-1:0]   out_hun_reg;
    logic [CLS_W-1:0]   out_cls_reg;
    logic               load_out;

    logic               div_done;
    logic [DIV_N-1:0]   div_quot;

    logic [PROD1_W-1:0] mq_prod;
    logic [DIV_N-1:0]   frac_full;
    logic [PROD2_W-1:0] kilo_prod;
    logic [KILO_W-1:0]  kilo_bias;
    logic [PROD3_W-1:0] hun_prod;

    rpfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (REF_HZ),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // one registered step per cycle: 2q / 15625, its remainder r, 8r / 125, (k + 5) / 10
    assign mq_prod   = PROD1_W'(twoq_reg) * PROD1_W'(RECIP_MHZ);
    assign frac_full = twoq_reg - DIV_N'(mq_reg) * DIV_N'(MHZ_DIV);
    assign kilo_prod = PROD2_W'(frac_reg) * PROD2_W'(RECIP_KILO);
    assign kilo_bias = kilo_reg + HUN_BIAS;
    assign hun_prod  = PROD3_W'(kilo_bias) * PROD3_W'(RECIP_HUN);

    always_comb
    begin
        state_next     = state_reg;
        ok_next        = ok_reg;
        cls_next       = cls_reg;
        mhz_next       = mhz_reg;
        hun_next       = hun_reg;
        div_start_next = 1'b0;
        div_dsr_next   = div_dsr_reg;
        twoq_next      = twoq_reg;
        mq_next        = mq_reg;
        frac_next      = frac_reg;
        kilo_next      = kilo_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    ok_next  = q_job.ok;
                    cls_next = q_job.cls;
                    if (q_job.ok)
                    begin
                        div_start_next = 1'b1;
                        div_dsr_next   = DIV_D'(q_job.base);
                        state_next     = ST_QUOT;
                    end
                    else
                    begin
                        mhz_next   = '0;
                        hun_next   = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_QUOT:
            begin
                // f = q*128; f/1e6 = 2q/15625
                if (div_done)
                begin
                    twoq_next  = {div_quot[DIV_N-2:0], 1'b0};
                    state_next = ST_MHZ;
                end
            end
            ST_MHZ:
            begin
                mq_next    = mq_prod[RECIP_MHZ_SH +: MQ_W];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                // thousandths k = r*64/1000 = r*8/125
                mhz_next   = (mq_reg > MHZ_LIMIT) ? MHZ_LIMIT[MHZ_W-1:0]
                                                  : mq_reg[MHZ_W-1:0];
                frac_next  = frac_full[MQ_W-1:0];
                state_next = ST_KILO;
            end
            ST_KILO:
            begin
                kilo_next  = kilo_prod[RECIP_KILO_SH +: KILO_W];
                state_next = ST_HUN;
            end
            ST_HUN:
            begin
                // round half up: (k + 5) / 10
                hun_next   = hun_prod[RECIP_HUN_SH +: HUN_W];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        cls_reg      <= cls_next;
        mhz_reg      <= mhz_next;
        hun_reg      <= hun_next;
        div_dsr_reg  <= div_dsr_next;
        twoq_reg     <= twoq_next;
        mq_reg       <= mq_next;
        frac_reg     <= frac_next;
        kilo_reg     <= kilo_next;
        if (load_out)
        begin
            out_ok_reg  <= ok_reg;
            out_mhz_reg <= mhz_reg;
            out_hun_reg <= hun_reg;
            out_cls_reg <= cls_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_mhz   = out_mhz_reg;
    assign out_hun   = out_hun_reg;
    assign out_cls   = out_cls_reg;

    // an invalid base reports zero frequency
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_mhz_reg == '0 && out_hun_reg == '0))
        else $error("invalid result carries a nonzero frequency");

    // rounded hundredths never exceed one whole MHz
    a_hun_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_hun_reg <= HUN_W'(100)))
        else $error("hundredths out of range");

    // divider completes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_QUOT))
        else $error("divider finished outside a division pass");

    // the divider does not report done right after a start
    a_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |=> !div_done)
        else $error("divider done right after start");

endmodule

// ===== sv/rf_period_frequency_classifier.sv =====
// top level of the rf period/frequency classifier
//
// input stream (s_axis): one request per transaction; tuser carries the request
// kind (start, capture edge, timeout), tdata the 16-bit timer stamp of a capture.
// the front end decodes a request in the cycle it is accepted, so requests are
// taken one per cycle while the result queue has room.
// a run that ends (ask, fsk or timeout) places one job in a two-entry queue.
// output stream (m_axis): one transaction per finished run; tuser is the
// frequency-valid flag, tdata holds mhz, hundredths and modulation class.
// a run with a valid base passes the queue, a divider pass for 108e6 / base, the
// reciprocal multiplies (mhz, remainder, thousandths, rounded hundredths) and the
// output register before m_axis_tvalid rises. an out-of-range base skips the
// divider and the multiplies; the back end takes a new run from the queue only
// once the last one has been loaded into the output register.
// configuration (cfg_we, cfg_index, cfg_data) must be written by the user while no run
// result is pending; the block does not enforce it. index 0 min period, 1 max period, 2 scan limit.
// reset clears the run state, the class, the queue and the output valid flag and
// loads the default limits 13, 46 and 32.
// when m_axis_tready is low the result holds; the queue then takes two more
// finished runs before s_axis_tready drops.
module rf_period_frequency_classifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rpfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // stamp
    input  logic [1:0]                       s_axis_tuser,   // req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rpfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // mhz, hundredths, mod_class
    output logic                             m_axis_tuser,   // freq_valid
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [rpfc_pkg::PERIOD_W-1:0]    cfg_data
);
    import rpfc_pkg::*;

    logic             q_full;
    logic             q_push;
    job_t             q_wdata;
    logic             q_pop;
    logic             q_not_empty;
    job_t             q_rdata;
    logic [MHZ_W-1:0] out_mhz;
    logic [HUN_W-1:0] out_hun;
    logic [CLS_W-1:0] out_cls;

    rpfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_axis_tuser),
        .in_stamp  (s_axis_tdata[STAMP_BITS-1:0]),
        .q_full    (q_full),
        .push      (q_push),
        .job       (q_wdata)
    );

    rpfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    rpfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_job     (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ok    (m_axis_tuser),
        .out_mhz   (out_mhz),
        .out_hun   (out_hun),
        .out_cls   (out_cls)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_cls, out_hun, out_mhz});

endmodule
